// ----- design/bkle_pkg.sv -----
// bounded key list engine: shared types and constants
// used by bkle_ctrl, bkle_dp and bounded_key_list_engine_top
package bkle_pkg;

  localparam int KeyW  = 32;
  localparam int KindW = 2;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 2'd0,
    KIND_FRONT  = 2'd1,
    KIND_SORTED = 2'd2,
    KIND_FIND   = 2'd3
  } bkle_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } bkle_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ins;
    logic res_ok;
    logic res_fail;
    logic scan_init;
    logic rot;
    logic emit;
  } bkle_cmd_t;

  // datapath to controller
  typedef struct packed {
    bkle_kind_e kind;
    logic       full;
    logic       no_match;
    logic       out_free;
    logic       emit_now;
    logic       scan_last;
  } bkle_sts_t;

endpackage

// ----- design/bkle_dp.sv -----
// bounded key list engine datapath: key cells, count, compare masks,
// scan rotation and output register; depends on bkle_pkg
module bkle_dp #(
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bkle_pkg::bkle_cmd_t      cmd_i,
  output bkle_pkg::bkle_sts_t      sts_o,
  input  logic [bkle_pkg::KindW-1:0] kind_i,
  input  logic [bkle_pkg::KeyW-1:0]  key_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     out_ok_o,
  output logic [bkle_pkg::KeyW-1:0]  out_key_o,
  output logic                     out_last_o
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int StepW = $clog2(DEPTH);

  logic [bkle_pkg::KeyW-1:0] ent_q [DEPTH];
  logic [bkle_pkg::KeyW-1:0] ent_d [DEPTH];
  logic [CntW-1:0]           cnt_q, cnt_d;
  bkle_pkg::bkle_kind_e      kind_q;
  logic [bkle_pkg::KeyW-1:0] key_q;
  logic [DEPTH-1:0]          eq, ge, at_cnt, sel, first, low;
  logic [DEPTH-1:0]          mask_q;
  logic                      hit_q;
  logic [StepW-1:0]          step_q;
  logic                      out_valid_q, out_ok_q, out_last_q;
  logic [bkle_pkg::KeyW-1:0] out_key_q;
  logic                      out_free;

  // per-cell compares
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      eq[i]     = (CntW'(i) < cnt_q) && (ent_q[i] == key_q);
      ge[i]     = (CntW'(i) < cnt_q) && ($signed(ent_q[i]) >= $signed(key_q));
      at_cnt[i] = (CntW'(i) == cnt_q);
    end
  end

  always_comb begin
    unique case (kind_q)
      bkle_pkg::KIND_APPEND: sel = at_cnt;
      bkle_pkg::KIND_FRONT:  sel = DEPTH'(1);
      bkle_pkg::KIND_SORTED: sel = ge | at_cnt;
      default:               sel = at_cnt;
    endcase
  end

  // insert position as one-hot, and mask of cells below it
  assign first = sel & (~sel + DEPTH'(1));
  assign low   = first - DEPTH'(1);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_d[i] = ent_q[i];
      if (cmd_i.ins) begin
        if (first[i]) begin
          ent_d[i] = key_q;
        end else if (!low[i] && i > 0) begin
          ent_d[i] = ent_q[(i > 0) ? i - 1 : 0];
        end
      end else if (cmd_i.rot) begin
        if (CntW'(i) == cnt_q - CntW'(1)) begin
          ent_d[i] = ent_q[0];
        end else if (i < DEPTH - 1) begin
          ent_d[i] = ent_q[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign cnt_d = cmd_i.ins ? cnt_q + CntW'(1) : cnt_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_q[i] <= ent_d[i];
    end
    if (cmd_i.load) begin
      key_q <= key_i;
    end
    if (cmd_i.scan_init) begin
      mask_q <= eq;
      step_q <= '0;
    end else if (cmd_i.rot) begin
      mask_q <= mask_q >> 1;
      step_q <= step_q + StepW'(1);
    end
    if (cmd_i.res_ok || cmd_i.res_fail || cmd_i.emit) begin
      out_ok_q   <= cmd_i.res_ok || cmd_i.emit;
      out_key_q  <= cmd_i.emit ? ent_q[0] : '0;
      out_last_q <= cmd_i.emit ? sts_o.scan_last : 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      kind_q      <= bkle_pkg::KIND_APPEND;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.load) begin
        kind_q <= bkle_pkg::bkle_kind_e'(kind_i);
      end
      if (cmd_i.scan_init) begin
        hit_q <= 1'b0;
      end else if (cmd_i.rot) begin
        hit_q <= hit_q | mask_q[0];
      end
      if (cmd_i.res_ok || cmd_i.res_fail || cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.kind      = kind_q;
  assign sts_o.full      = (cnt_q == CntW'(DEPTH));
  assign sts_o.no_match  = ~|eq;
  assign sts_o.out_free  = out_free;
  assign sts_o.emit_now  = hit_q | mask_q[0];
  assign sts_o.scan_last = (CntW'(step_q) + CntW'(1) == cnt_q);

  assign out_valid_o = out_valid_q;
  assign out_ok_o    = out_ok_q;
  assign out_key_o   = out_key_q;
  assign out_last_o  = out_last_q;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("count above depth");

  a_result_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.res_ok || cmd_i.res_fail || cmd_i.emit) |-> out_free)
    else $error("result written over a pending word");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.ins |=> $stable(cnt_q))
    else $error("count moved without insert");

  a_ins_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ins |-> !sts_o.full)
    else $error("insert into full list");

endmodule

// ----- design/bkle_ctrl.sv -----
// bounded key list engine controller: sequences accept, insert and scan
// depends on bkle_pkg
module bkle_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bkle_pkg::bkle_sts_t sts_i,
  output bkle_pkg::bkle_cmd_t cmd_o
);

  bkle_pkg::bkle_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bkle_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = bkle_pkg::ST_EXEC;
        end
      end
      bkle_pkg::ST_EXEC: begin
        if (sts_i.out_free) begin
          if (sts_i.kind == bkle_pkg::KIND_FIND && !sts_i.no_match) begin
            state_d = bkle_pkg::ST_SCAN;
          end else begin
            state_d = bkle_pkg::ST_IDLE;
          end
        end
      end
      bkle_pkg::ST_SCAN: begin
        if (sts_i.out_free && sts_i.scan_last) begin
          state_d = bkle_pkg::ST_IDLE;
        end
      end
      default: state_d = bkle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      bkle_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      bkle_pkg::ST_EXEC: begin
        if (sts_i.out_free) begin
          if (sts_i.kind == bkle_pkg::KIND_FIND) begin
            cmd_o.res_fail  = sts_i.no_match;
            cmd_o.scan_init = !sts_i.no_match;
          end else if (sts_i.full) begin
            cmd_o.res_fail = 1'b1;
          end else begin
            cmd_o.ins    = 1'b1;
            cmd_o.res_ok = 1'b1;
          end
        end
      end
      bkle_pkg::ST_SCAN: begin
        cmd_o.rot  = sts_i.out_free;
        cmd_o.emit = sts_i.out_free && sts_i.emit_now;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bkle_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.res_ok, cmd_o.res_fail, cmd_o.emit}) <= 1)
    else $error("two results in one cycle");

  a_scan_ends_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bkle_pkg::ST_SCAN && sts_i.out_free && sts_i.scan_last)
      |-> cmd_o.emit)
    else $error("scan ended without final word");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == bkle_pkg::ST_EXEC)
    else $error("load not followed by execute");

endmodule

// ----- design/bounded_key_list_engine_top.sv -----
// Bounded key list engine: keeps up to DEPTH signed keys in register cells.
// An insert (append, front or sorted) is accepted in the idle state; in the
// execute state all cells are then compared in parallel and shifted in one
// step. A lookup is accepted the same way and then compares all cells; a
// miss ends there, a hit then enters a scan in which the valid cells rotate
// once through position zero, one word going out per cycle from the
// matching entry on; the rotation leaves the list as it was. A new word is
// accepted only when the previous one is finished; output backpressure
// stalls the sequence. Depends on bkle_pkg, bkle_ctrl and bkle_dp.
module bounded_key_list_engine_top #(
  parameter int DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // entry_key
  output logic        m_axis_tuser,   // ok
  output logic        m_axis_tlast    // last
);

  bkle_pkg::bkle_cmd_t cmd;
  bkle_pkg::bkle_sts_t sts;

  bkle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bkle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (s_axis_tuser),
    .key_i       (s_axis_tdata),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ok_o    (m_axis_tuser),
    .out_key_o   (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench for bounded_key_list_engine_top: appends, front and sorted inserts
// and lookups with random idling, checked word by word against a scoreboard
// that keeps its own copy of the key list; depends on bkle_pkg and the rtl
`timescale 1ns / 100ps

module tb_top;

  localparam int ListDepth = 32;
  localparam int StallLimit = 4000;
  localparam int HoldOff = 300;

  class key_list_scoreboard;
    typedef struct {
      logic        ok;
      logic [31:0] key;
      logic        last;
    } list_reply_t;

    logic [31:0]  cells[ListDepth];
    int unsigned  fill = 0;
    list_reply_t  pending[$];
    int unsigned  errors = 0;

    function void push_reply(logic ok, logic [31:0] key, logic last);
      list_reply_t r;
      r.ok = ok;
      r.key = key;
      r.last = last;
      pending.push_back(r);
    endfunction

    function void note_word(bkle_pkg::bkle_kind_e kind, logic [31:0] key);
      int unsigned pos;
      int unsigned i;
      if (kind == bkle_pkg::KIND_FIND) begin
        pos = fill;
        for (i = 0; i < fill; i++) begin
          if (cells[i] == key) begin
            pos = i;
            break;
          end
        end
        if (pos >= fill) begin
          push_reply(1'b0, 32'd0, 1'b1);
        end else begin
          for (i = pos; i < fill; i++) push_reply(1'b1, cells[i], i + 1 == fill);
        end
        return;
      end
      if (fill >= ListDepth) begin
        push_reply(1'b0, 32'd0, 1'b1);
        return;
      end
      case (kind)
        bkle_pkg::KIND_APPEND: pos = fill;
        bkle_pkg::KIND_FRONT:  pos = 0;
        default: begin
          pos = 0;
          while (pos < fill && $signed(cells[pos]) < $signed(key)) pos++;
        end
      endcase
      for (i = fill; i > pos; i--) cells[i] = cells[i-1];
      cells[pos] = key;
      fill++;
      push_reply(1'b1, 32'd0, 1'b1);
    endfunction

    function void check_word(logic ok, logic [31:0] key, logic last);
      list_reply_t want;
      if (pending.size() == 0) begin
        $error("unexpected word: ok=%0b entry_key=%0d last=%0b", ok, $signed(key), last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (ok !== want.ok) begin
        $error("ok: expected %0b, got %0b", want.ok, ok);
        errors++;
      end
      if (key !== want.key) begin
        $error("entry_key: expected %0d, got %0d", $signed(want.key), $signed(key));
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // key
  logic [1:0]  s_axis_tuser;   // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;   // entry_key
  logic        m_axis_tuser;   // ok
  logic        m_axis_tlast;   // last

  key_list_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold = 0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int stall_cycles = 0;

  bounded_key_list_engine_top #(
    .DEPTH(ListDepth)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // receiver with random stalls and an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_req && !hold_taken) begin
      rx_hold = HoldOff;
      hold_taken = 1'b1;
    end
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold = rx_hold - 1;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tuser, m_axis_tdata, m_axis_tlast);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles = stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic send_word(bkle_pkg::bkle_kind_e kind, logic [31:0] key);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_word(kind, key);
  endtask

  // stop offering and let every pending word come out
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (ListDepth + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($signed($urandom_range(0, 15)) - 8);
      4: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int n, int tx_pct, int rx_pct);
    bkle_pkg::bkle_kind_e kind;
    logic [31:0]          key;
    @(posedge clk_i);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    repeat (n) begin
      if ($urandom_range(0, 99) < 35) begin
        kind = bkle_pkg::bkle_kind_e'($urandom_range(0, 2));
        key = pick_key();
      end else begin
        kind = bkle_pkg::KIND_FIND;
        if (sb.fill > 0 && $urandom_range(0, 9) < 7)
          key = sb.cells[$urandom_range(0, sb.fill - 1)];
        else
          key = pick_key();
      end
      send_word(kind, key);
    end
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: lookup on empty list, extreme keys, equal keys, no match
    send_word(bkle_pkg::KIND_FIND, 32'd5);
    send_word(bkle_pkg::KIND_APPEND, 32'h7fff_ffff);
    send_word(bkle_pkg::KIND_APPEND, 32'h8000_0000);
    send_word(bkle_pkg::KIND_APPEND, 32'h0000_0000);
    send_word(bkle_pkg::KIND_APPEND, 32'hffff_ffff);
    send_word(bkle_pkg::KIND_FRONT, 32'h5555_5555);
    send_word(bkle_pkg::KIND_FRONT, 32'haaaa_aaaa);
    send_word(bkle_pkg::KIND_SORTED, 32'h0000_0000);
    send_word(bkle_pkg::KIND_SORTED, 32'h8000_0000);
    send_word(bkle_pkg::KIND_SORTED, 32'h7fff_ffff);
    send_word(bkle_pkg::KIND_SORTED, 32'hffff_ffff);
    send_word(bkle_pkg::KIND_SORTED, 32'd7);
    send_word(bkle_pkg::KIND_APPEND, 32'h0f0f_0f0f);
    send_word(bkle_pkg::KIND_FIND, 32'haaaa_aaaa);
    send_word(bkle_pkg::KIND_FIND, 32'h7fff_ffff);
    send_word(bkle_pkg::KIND_FIND, 32'h0000_0000);
    send_word(bkle_pkg::KIND_FIND, 32'd7);
    send_word(bkle_pkg::KIND_FIND, 32'h0f0f_0f0f);
    send_word(bkle_pkg::KIND_FIND, 32'h1234_5678);
    send_word(bkle_pkg::KIND_FIND, 32'h8000_0000);
    drain();

    run_random(45, 0, 0);
    run_random(45, 81, 0);
    hold_req = 1'b1;
    run_random(45, 0, 81);
    run_random(45, 33, 33);

    if (sb.pending.size() != 0) begin
      $error("%0d expected words never came", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
